// ===== rtl/s20_pkg.sv =====
// s20_pkg: shared types and constants for the salsa20 stream cipher
// no dependencies
package s20_pkg;
   localparam int BlockBytes = 64;
   localparam int IdxW = 6;
   localparam int AddrW = 6;

   localparam logic [AddrW-1:0] RegKey0   = 6'd0;
   localparam logic [AddrW-1:0] RegKey1   = 6'd8;
   localparam logic [AddrW-1:0] RegKey2   = 6'd16;
   localparam logic [AddrW-1:0] RegKey3   = 6'd24;
   localparam logic [AddrW-1:0] RegLong   = 6'd32;
   localparam logic [AddrW-1:0] RegNonce  = 6'd40;
   localparam logic [AddrW-1:0] RegStart  = 6'd48;
   localparam logic [AddrW-1:0] RegRounds = 6'd56;

   localparam logic CmdCrypt   = 1'b0;
   localparam logic CmdRestart = 1'b1;

   localparam logic [31:0] Sig1 = 32'h3320646e;
   localparam logic [31:0] Sig2 = 32'h79622d32;
   localparam logic [31:0] Tau1 = 32'h3120646e;
   localparam logic [31:0] Tau2 = 32'h79622d36;
   localparam logic [31:0] Kc0  = 32'h61707865;
   localparam logic [31:0] Kc3  = 32'h6b206574;

   typedef logic [31:0] word_type;
   typedef word_type [15:0] matrix_type;

   // one queued word from the front to the back
   typedef struct packed {
      logic       restart;
      logic [7:0] data;
   } qent_type;

   typedef struct packed {
      logic [63:0] key0;
      logic [63:0] key1;
      logic [63:0] key2;
      logic [63:0] key3;
      logic        long_key;
      logic [63:0] nonce;
      logic [63:0] start;
      logic [4:0]  rounds;
   } cfg_type;

   function automatic word_type rotl(input word_type v, input int s);
      rotl = (v << s) | (v >> (32 - s));
   endfunction

   function automatic matrix_type qr(input matrix_type xi, input int a, input int b,
                                     input int c, input int d);
      matrix_type x;
      x = xi;
      x[b] = x[b] ^ rotl(x[a] + x[d], 7);
      x[c] = x[c] ^ rotl(x[b] + x[a], 9);
      x[d] = x[d] ^ rotl(x[c] + x[b], 13);
      x[a] = x[a] ^ rotl(x[d] + x[c], 18);
      return x;
   endfunction

   // column round then row round
   function automatic matrix_type dround(input matrix_type xi);
      matrix_type x;
      x = xi;
      x = qr(x, 0, 4, 8, 12);
      x = qr(x, 5, 9, 13, 1);
      x = qr(x, 10, 14, 2, 6);
      x = qr(x, 15, 3, 7, 11);
      x = qr(x, 0, 1, 2, 3);
      x = qr(x, 5, 6, 7, 4);
      x = qr(x, 10, 11, 8, 9);
      x = qr(x, 15, 12, 13, 14);
      return x;
   endfunction
endpackage

// ===== rtl/s20_req_if.sv =====
// s20_req_if: request and response channel interfaces
// depends on nothing
interface s20_req_if;
   logic       valid;
   logic       ready;
   logic       command;
   logic [7:0] data_byte;
   modport source (output valid, command, data_byte, input ready);
   modport sink (input valid, command, data_byte, output ready);
endinterface

interface s20_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       counter_wrapped;
   modport source (output valid, out_byte, counter_wrapped, input ready);
   modport sink (input valid, out_byte, counter_wrapped, output ready);
endinterface

// ===== rtl/s20_front.sv =====
// s20_front: accepts request words and holds them in a short queue
// depends on s20_pkg
module s20_front (
   input  logic               clock,
   input  logic               reset,
   s20_req_if.sink            req,
   output s20_pkg::qent_type  q_data,
   output logic               q_valid,
   input  logic               q_pop
);
   import s20_pkg::*;
   qent_type   mem_ff [4];
   logic [1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [2:0] cnt_ff, cnt_in;
   logic       push;

   assign req.ready = (cnt_ff != 3'd4);
   assign push = req.valid && req.ready;
   assign q_valid = (cnt_ff != 3'd0);
   assign q_data = mem_ff[rp_ff];

   // pointer and fill count
   always_comb begin
      wp_in = wp_ff + 2'(push);
      rp_in = rp_ff + 2'(q_pop);
      cnt_in = cnt_ff + 3'(push) - 3'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff <= wp_in;
         rp_ff <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wp_ff] <= '{restart: req.command == CmdRestart, data: req.data_byte};
      end
   end
endmodule

// ===== rtl/s20_back.sv =====
// s20_back: keystream generation, byte crypt and output register
// depends on s20_pkg
module s20_back (
   input  logic               clock,
   input  logic               reset,
   input  s20_pkg::cfg_type   cfg,
   input  s20_pkg::qent_type  q_data,
   input  logic               q_valid,
   output logic               q_pop,
   s20_rsp_if.source          rsp
);
   import s20_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_ROUND = 3'b010,
      ST_FEED  = 3'b100
   } state_type;

   state_type   state_ff, state_in;
   matrix_type  init_ff, x_ff;
   logic [63:0] ctr_ff, ctr_in;
   logic [6:0]  left_ff, left_in;
   logic [4:0]  dr_ff;
   logic [4:0]  r;
   logic [IdxW-1:0] idx;
   logic        ov_ff, ov_in;
   logic [7:0]  ob_ff, ob_in;
   logic        ow_ff, ow_in;
   logic        out_free;
   logic        start_blk;
   matrix_type  init_w;
   logic [63:0] hi0, hi1;
   word_type    ks_sum;
   logic [7:0]  ks_byte;

   assign out_free = !ov_ff || rsp.ready;
   assign rsp.valid = ov_ff;
   assign rsp.out_byte = ob_ff;
   assign rsp.counter_wrapped = ow_ff;
   assign idx = IdxW'(7'(BlockBytes) - left_ff);
   assign r = (cfg.rounds == 5'd0) ? 5'd20 : cfg.rounds;

   // feed-forward sum for the current keystream byte
   assign ks_sum = x_ff[idx[5:2]] + init_ff[idx[5:2]];
   assign ks_byte = ks_sum[{idx[1:0], 3'b000} +: 8];

   // initial matrix
   always_comb begin
      hi0 = cfg.long_key ? cfg.key2 : cfg.key0;
      hi1 = cfg.long_key ? cfg.key3 : cfg.key1;
      init_w[0] = Kc0;
      init_w[1] = cfg.key0[31:0];
      init_w[2] = cfg.key0[63:32];
      init_w[3] = cfg.key1[31:0];
      init_w[4] = cfg.key1[63:32];
      init_w[5] = cfg.long_key ? Sig1 : Tau1;
      init_w[6] = cfg.nonce[31:0];
      init_w[7] = cfg.nonce[63:32];
      init_w[8] = ctr_ff[31:0];
      init_w[9] = ctr_ff[63:32];
      init_w[10] = cfg.long_key ? Sig2 : Tau2;
      init_w[11] = hi0[31:0];
      init_w[12] = hi0[63:32];
      init_w[13] = hi1[31:0];
      init_w[14] = hi1[63:32];
      init_w[15] = Kc3;
   end

   // control
   always_comb begin
      state_in = state_ff;
      ctr_in = ctr_ff;
      left_in = left_ff;
      ov_in = ov_ff && !rsp.ready;
      ob_in = ob_ff;
      ow_in = ow_ff;
      q_pop = 1'b0;
      start_blk = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid && out_free) begin
               if (q_data.restart) begin
                  q_pop = 1'b1;
                  ctr_in = cfg.start;
                  left_in = '0;
                  ov_in = 1'b1;
                  ob_in = '0;
                  ow_in = 1'b0;
               end else if (left_ff == 7'd0) begin
                  start_blk = 1'b1;
                  state_in = ST_ROUND;
               end else begin
                  q_pop = 1'b1;
                  left_in = left_ff - 7'd1;
                  ov_in = 1'b1;
                  ob_in = q_data.data ^ ks_byte;
                  ow_in = 1'b0;
               end
            end
         end
         ST_ROUND: begin
            if (dr_ff == 5'd1) state_in = ST_FEED;
         end
         ST_FEED: begin
            ctr_in = ctr_ff + 64'd1;
            state_in = ST_IDLE;
            if (ctr_ff + 64'd1 == 64'd0) begin
               q_pop = 1'b1;
               ov_in = 1'b1;
               ob_in = '0;
               ow_in = 1'b1;
            end else begin
               left_in = 7'(BlockBytes);
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ctr_ff <= '0;
         left_ff <= '0;
         ov_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ctr_ff <= ctr_in;
         left_ff <= left_in;
         ov_ff <= ov_in;
      end
   end

   always_ff @(posedge clock) begin
      ob_ff <= ob_in;
      ow_ff <= ow_in;
   end

   // one double round per cycle
   always_ff @(posedge clock) begin
      if (start_blk) begin
         init_ff <= init_w;
         x_ff <= init_w;
         dr_ff <= 5'((6'(r) + 6'd1) >> 1);
      end else if (state_ff == ST_ROUND) begin
         x_ff <= dround(x_ff);
         dr_ff <= dr_ff - 5'd1;
      end
   end
endmodule

// ===== rtl/s20_csr.sv =====
// s20_csr: configuration registers behind the csr port
// depends on s20_pkg
module s20_csr (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [s20_pkg::AddrW-1:0] csr_paddr,
   input  logic [63:0]            csr_pwdata,
   output logic [63:0]            csr_prdata,
   output logic                   csr_pready,
   output s20_pkg::cfg_type       cfg
);
   import s20_pkg::*;
   cfg_type cfg_ff;
   logic    we;

   assign cfg = cfg_ff;
   assign csr_pready = 1'b1;
   assign we = csr_psel && csr_penable && csr_pwrite;

   // readback
   always_comb begin
      unique case (csr_paddr)
         RegKey0:   csr_prdata = cfg_ff.key0;
         RegKey1:   csr_prdata = cfg_ff.key1;
         RegKey2:   csr_prdata = cfg_ff.key2;
         RegKey3:   csr_prdata = cfg_ff.key3;
         RegLong:   csr_prdata = 64'(cfg_ff.long_key);
         RegNonce:  csr_prdata = cfg_ff.nonce;
         RegStart:  csr_prdata = cfg_ff.start;
         RegRounds: csr_prdata = 64'(cfg_ff.rounds);
         default:   csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{key0: '0, key1: '0, key2: '0, key3: '0, long_key: 1'b1,
                     nonce: '0, start: '0, rounds: 5'd20};
      end else if (we) begin
         unique case (csr_paddr)
            RegKey0:   cfg_ff.key0 <= csr_pwdata;
            RegKey1:   cfg_ff.key1 <= csr_pwdata;
            RegKey2:   cfg_ff.key2 <= csr_pwdata;
            RegKey3:   cfg_ff.key3 <= csr_pwdata;
            RegLong:   cfg_ff.long_key <= csr_pwdata[0];
            RegNonce:  cfg_ff.nonce <= csr_pwdata;
            RegStart:  cfg_ff.start <= csr_pwdata;
            RegRounds: cfg_ff.rounds <= csr_pwdata[4:0];
            default:   ;
         endcase
      end
   end
endmodule

// ===== rtl/salsa20_stream_cipher_top.sv =====
// salsa20_stream_cipher_top: byte-wide salsa20 keystream cipher
// depends on s20_pkg, s20_req_if, s20_front, s20_back, s20_csr
//
//   port   dir  handshake      contents
//   req    in   valid/ready    command, data_byte
//   rsp    out  valid/ready    out_byte, counter_wrapped
//   csr    in   apb            eight 64-bit registers at 8*i
//
// a byte from stored keystream is crypted straight from the held block; a byte that
// needs a new block first waits for (rounds+1)/2 double rounds (rounds 0 counts as 20),
// one double round per cycle in the round unit
// reset is synchronous and clears queue, counter and byte count
// a stalled rsp holds the output register; the 4-word queue then fills
module salsa20_stream_cipher_top (
   input  logic        clock,
   input  logic        reset,
   s20_req_if.sink     req,
   s20_rsp_if.source   rsp,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [5:0]  csr_paddr,
   input  logic [63:0] csr_pwdata,
   output logic [63:0] csr_prdata,
   output logic        csr_pready
);
   import s20_pkg::*;
   qent_type q_data;
   logic     q_valid, q_pop;
   cfg_type  cfg;

   s20_csr u_csr (.clock, .reset, .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr,
                  .csr_pwdata, .csr_prdata, .csr_pready, .cfg);
   s20_front u_front (.clock, .reset, .req, .q_data, .q_valid, .q_pop);
   s20_back u_back (.clock, .reset, .cfg, .q_data, .q_valid, .q_pop, .rsp);
endmodule

// ===== rtl/s20_checker.sv =====
// s20_checker: port-level checks for the cipher top
// depends on the top level through bind
module s20_checker (
   input logic clock,
   input logic reset,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic [7:0] rsp_out_byte,
   input logic rsp_counter_wrapped,
   input logic csr_pready
);
   // a wrap word carries a zero byte
   a_wrap_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_counter_wrapped |-> rsp_out_byte == 8'd0)
      else $error("wrap with nonzero byte");
   // stalled word holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte))
      else $error("rsp dropped");
   // no output right after reset
   a_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp valid after reset");
   a_pready: assert property (@(posedge clock) csr_pready)
      else $error("pready low");
endmodule

bind salsa20_stream_cipher_top s20_checker u_chk (
   .clock, .reset, .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
   .rsp_out_byte(rsp.out_byte), .rsp_counter_wrapped(rsp.counter_wrapped),
   .csr_pready);

// ===== sim/s20_checker.sv =====
// s20_scoreboard: watches the salsa20 cipher channels and register port,
// predicts each result word and compares it; depends on s20_pkg, s20_req_if
module s20_scoreboard (
   input  logic        clock,
   input  logic        reset,
   s20_req_if          req,
   s20_rsp_if          rsp,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic        csr_pready,
   input  logic [5:0]  csr_paddr,
   input  logic [63:0] csr_pwdata,
   output int          mismatches,
   output int          backlog
);
   import s20_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [7:0] out_byte;
      logic       wrapped;
   } cipher_word_type;

   // shadow of the register file
   logic [63:0] key_lo, key_mid, key_hi0, key_hi1, nonce_reg, start_reg;
   logic        long_key_reg;
   logic [4:0]  rounds_reg;

   // shadow of the stream state
   logic [63:0] block_ctr;
   int          bytes_left;
   logic [7:0]  stream_bytes[64];
   logic [31:0] seed[16];
   logic [31:0] churn[16];

   cipher_word_type pending_words[$];

   function automatic logic [31:0] spin(input logic [31:0] v, input int s);
      return (v << s) | (v >> (32 - s));
   endfunction

   function automatic void stir(input int a, input int b, input int c, input int d);
      churn[b] = churn[b] ^ spin(churn[a] + churn[d], 7);
      churn[c] = churn[c] ^ spin(churn[b] + churn[a], 9);
      churn[d] = churn[d] ^ spin(churn[c] + churn[b], 13);
      churn[a] = churn[a] ^ spin(churn[d] + churn[c], 18);
   endfunction

   // build the next 64 keystream bytes from the current counter
   function automatic void refill_stream();
      logic [63:0] hi0, hi1;
      logic [31:0] w;
      int r, dr;
      hi0 = long_key_reg ? key_hi0 : key_lo;
      hi1 = long_key_reg ? key_hi1 : key_mid;
      r = int'(rounds_reg);
      if (r == 0) r = 20;
      dr = (r + 1) / 2;
      seed[0]  = 32'h61707865;
      seed[5]  = long_key_reg ? 32'h3320646e : 32'h3120646e;
      seed[10] = long_key_reg ? 32'h79622d32 : 32'h79622d36;
      seed[15] = 32'h6b206574;
      seed[1]  = key_lo[31:0];
      seed[2]  = key_lo[63:32];
      seed[3]  = key_mid[31:0];
      seed[4]  = key_mid[63:32];
      seed[6]  = nonce_reg[31:0];
      seed[7]  = nonce_reg[63:32];
      seed[8]  = block_ctr[31:0];
      seed[9]  = block_ctr[63:32];
      seed[11] = hi0[31:0];
      seed[12] = hi0[63:32];
      seed[13] = hi1[31:0];
      seed[14] = hi1[63:32];
      for (int i = 0; i < 16; i++) churn[i] = seed[i];
      for (int i = 0; i < dr; i++) begin
         stir(0, 4, 8, 12);
         stir(5, 9, 13, 1);
         stir(10, 14, 2, 6);
         stir(15, 3, 7, 11);
         stir(0, 1, 2, 3);
         stir(5, 6, 7, 4);
         stir(10, 11, 8, 9);
         stir(15, 12, 13, 14);
      end
      for (int i = 0; i < 16; i++) begin
         w = churn[i] + seed[i];
         for (int j = 0; j < 4; j++) stream_bytes[4*i + j] = w[8*j +: 8];
      end
   endfunction

   // expected result for one accepted request word
   function automatic cipher_word_type predict_cipher(input logic cmd, input logic [7:0] data);
      cipher_word_type e;
      e.out_byte = 8'h00;
      e.wrapped = 1'b0;
      if (cmd == CmdRestart) begin
         block_ctr = start_reg;
         bytes_left = 0;
      end else if (bytes_left == 0) begin
         refill_stream();
         block_ctr = block_ctr + 64'd1;
         if (block_ctr == 64'd0) begin
            e.wrapped = 1'b1;
         end else begin
            e.out_byte = data ^ stream_bytes[0];
            bytes_left = 63;
         end
      end else begin
         e.out_byte = data ^ stream_bytes[64 - bytes_left];
         bytes_left--;
      end
      return e;
   endfunction

   task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
      $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
      mismatches++;
   endtask

   always @(posedge clock) begin
      cipher_word_type e;
      if (reset) begin
         key_lo = '0; key_mid = '0; key_hi0 = '0; key_hi1 = '0;
         nonce_reg = '0; start_reg = '0;
         long_key_reg = 1'b1;
         rounds_reg = 5'd20;
         block_ctr = '0;
         bytes_left = 0;
         pending_words.delete();
      end else begin
         // register writes
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr)
               RegKey0:   key_lo = csr_pwdata;
               RegKey1:   key_mid = csr_pwdata;
               RegKey2:   key_hi0 = csr_pwdata;
               RegKey3:   key_hi1 = csr_pwdata;
               RegLong:   long_key_reg = csr_pwdata[0];
               RegNonce:  nonce_reg = csr_pwdata;
               RegStart:  start_reg = csr_pwdata;
               RegRounds: rounds_reg = csr_pwdata[4:0];
               default: ;
            endcase
         end
         // accepted request word
         if (req.valid && req.ready)
            pending_words.push_back(predict_cipher(req.command, req.data_byte));
         // accepted result word
         if (rsp.valid && rsp.ready) begin
            if (pending_words.size() == 0) begin
               report("unexpected word", {55'd0, rsp.counter_wrapped, rsp.out_byte}, 64'd0);
            end else begin
               e = pending_words.pop_front();
               if (rsp.out_byte !== e.out_byte) report("out_byte", rsp.out_byte, e.out_byte);
               if (rsp.counter_wrapped !== e.wrapped)
                  report("counter_wrapped", rsp.counter_wrapped, e.wrapped);
            end
         end
      end
      backlog <= pending_words.size();
   end
endmodule

// ===== sim/testbench.sv =====
// testbench: stimulus, register programming and verdict for the salsa20 cipher
// depends on s20_pkg, s20_req_if, s20_scoreboard and the cipher rtl
module testbench;
   import s20_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int IdleLimit = 20000;

   logic        clock = 1'b0;
   logic        reset;
   logic        csr_psel, csr_penable, csr_pwrite;
   logic [5:0]  csr_paddr;
   logic [63:0] csr_pwdata, csr_prdata;
   logic        csr_pready;
   int          mismatches, backlog;
   int          quiet_cycles;
   bit          steady_sender;

   s20_req_if req_ch();
   s20_rsp_if rsp_ch();

   salsa20_stream_cipher_top DUT (
      .clock(clock), .reset(reset), .req(req_ch), .rsp(rsp_ch),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   s20_scoreboard scoreboard (
      .clock(clock), .reset(reset), .req(req_ch), .rsp(rsp_ch),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_pready(csr_pready), .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata),
      .mismatches(mismatches), .backlog(backlog)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // receiver stalls: runs of ready, short stalls, rare long stalls
   initial begin
      int hold;
      logic level;
      hold = 0;
      level = 1'b1;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold == 0) begin
            case ($urandom_range(0, 9))
               0, 1, 2, 3, 4: begin level = 1'b1; hold = $urandom_range(1, 40); end
               9:             begin level = 1'b0; hold = $urandom_range(20, 60); end
               default:       begin level = 1'b0; hold = $urandom_range(1, 3); end
            endcase
         end
         rsp_ch.ready <= level;
         hold--;
      end
   end

   // watchdog on cycles with no word moving
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IdleLimit) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // register write: setup then access
   task automatic write_reg(input logic [5:0] addr, input logic [63:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // send one request word, returns at the accepting edge
   task automatic send_word(input logic cmd, input logic [7:0] data);
      req_ch.valid <= 1'b1;
      req_ch.command <= cmd;
      req_ch.data_byte <= data;
      do @(negedge clock); while (!req_ch.ready);
      @(posedge clock);
   endtask

   task automatic sender_gap();
      int n;
      n = 0;
      if (!steady_sender) begin
         case ($urandom_range(0, 29))
            0:                   n = $urandom_range(15, 50);
            1, 2, 3, 4, 5, 6, 7, 8, 9: n = $urandom_range(1, 3);
            default:             n = 0;
         endcase
      end
      if (n > 0) begin
         req_ch.valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // hold off until every result is back and the round unit is quiet
   task automatic drain();
      req_ch.valid <= 1'b0;
      do @(negedge clock); while (backlog != 0);
      repeat (30) @(posedge clock);
   endtask

   task automatic crypt_run(input int n);
      for (int i = 0; i < n; i++) begin
         send_word(CmdCrypt, 8'($urandom));
         sender_gap();
      end
   endtask

   initial begin
      logic [63:0] start_pick;
      reset = 1'b1;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= '0;
      csr_pwdata <= '0;
      req_ch.valid <= 1'b0;
      req_ch.command <= CmdCrypt;
      req_ch.data_byte <= 8'h00;
      steady_sender = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: zero key, 20 rounds, counter 0
      send_word(CmdCrypt, 8'h00);
      send_word(CmdCrypt, 8'hff);
      send_word(CmdCrypt, 8'h5a);
      drain();

      // all-ones registers, counter one below wrap
      write_reg(RegKey0, '1);
      write_reg(RegKey1, '1);
      write_reg(RegKey2, '1);
      write_reg(RegKey3, '1);
      write_reg(RegNonce, '1);
      write_reg(RegStart, '1);
      write_reg(RegRounds, 64'd31);
      send_word(CmdRestart, 8'hff);
      send_word(CmdCrypt, 8'ha5);    // counter wraps here
      send_word(CmdCrypt, 8'h00);    // block at counter 0
      send_word(CmdCrypt, 8'hff);
      drain();

      // short key, minimum rounds, restart mid block
      write_reg(RegLong, 64'd0);
      write_reg(RegRounds, 64'd1);
      write_reg(RegStart, 64'h0000_0000_ffff_ffff);
      send_word(CmdRestart, 8'h00);
      send_word(CmdCrypt, 8'h01);
      send_word(CmdCrypt, 8'h80);
      send_word(CmdRestart, 8'h00);
      send_word(CmdCrypt, 8'h7f);
      drain();

      // round count zero means twenty
      write_reg(RegLong, 64'd1);
      write_reg(RegRounds, 64'd0);
      write_reg(RegKey0, '0);
      send_word(CmdRestart, 8'h00);
      send_word(CmdCrypt, 8'h3c);
      send_word(CmdCrypt, 8'hc3);
      drain();

      // random phases with fresh settings, each opened by a restart
      for (int phase = 0; phase < 10; phase++) begin
         write_reg(RegKey0, {$urandom, $urandom});
         write_reg(RegKey1, {$urandom, $urandom});
         write_reg(RegKey2, {$urandom, $urandom});
         write_reg(RegKey3, {$urandom, $urandom});
         write_reg(RegLong, 64'($urandom_range(0, 1)));
         write_reg(RegNonce, {$urandom, $urandom});
         write_reg(RegRounds, 64'($urandom_range(0, 31)));
         case ($urandom_range(0, 3))
            0:       start_pick = 64'hffff_ffff_ffff_fffe;
            1:       start_pick = 64'h0000_0000_ffff_fffe;
            2:       start_pick = 64'd0;
            default: start_pick = {$urandom, $urandom};
         endcase
         write_reg(RegStart, start_pick);
         steady_sender = (phase % 3 == 1);
         send_word(CmdRestart, 8'($urandom));
         for (int i = 0; i < 150; i++) begin
            if (phase == 2 && i == 70) drain();
            if ($urandom_range(0, 39) == 0)
               send_word(CmdRestart, 8'($urandom));
            else
               send_word(CmdCrypt, 8'($urandom));
            sender_gap();
         end
         drain();
      end

      req_ch.valid <= 1'b0;
      do @(negedge clock); while (backlog != 0);
      repeat (40) @(posedge clock);
      if (mismatches == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end
endmodule
